### rtl/core/hashed_prefix_lru_index_macros.svh
// ============================================================================
// Assertion macros for the hashed prefix LRU index
// Shared property forms; simulation builds get checks, synthesis gets nothing.
// ============================================================================
`ifndef HASHED_PREFIX_LRU_INDEX_MACROS_SVH
`define HASHED_PREFIX_LRU_INDEX_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HPLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpli check failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HPLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpli check failed");
`else
`define HPLI_ASSERT_IMP(label, ante, cons)
`define HPLI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/hpli_pkg.sv
// ============================================================================
// hpli_pkg
// Types, codes and the FNV-1a fold shared by the prefix index and its cells.
// ============================================================================
package hpli_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam int unsigned SLOT_IDX_W = 4;

    typedef enum logic [1:0] {
        CMD_RECORD,
        CMD_LOOKUP,
        CMD_CLEAR,
        CMD_SAVINGS
    } hpli_cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_INVALID,
        STATUS_NOT_FOUND
    } hpli_status_t;

    typedef struct packed {
        hpli_cmd_t   cmd;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_byte;
        logic [19:0] count_value;
    } hpli_in_t;

    typedef struct packed {
        hpli_status_t status;
        logic [19:0]  found_depth;
        logic [63:0]  hit_total;
        logic [63:0]  miss_total;
        logic [63:0]  saved_total;
    } hpli_out_t;

    // Search token that walks the row of slot cells.
    typedef struct packed {
        logic                  valid;
        logic                  match;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic [19:0]           match_depth;
        logic                  empty;
        logic [SLOT_IDX_W-1:0] empty_idx;
        logic [31:0]           min_age;
        logic [SLOT_IDX_W-1:0] min_idx;
    } hpli_tok_t;

    // Slot update broadcast to every cell.
    typedef struct packed {
        logic                  clear_all;
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  key_en;
        logic                  depth_en;
        logic                  age_en;
        logic [63:0]           key;
        logic [19:0]           depth;
        logic [31:0]           age;
    } hpli_wr_t;

    // One FNV-1a step; the multiply by the prime is a fixed shift-and-add.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

### rtl/core/hpli_cell.sv
// ============================================================================
// hpli_cell
// One table slot: holds key, depth and age, and folds itself into the
// search token passed on to the next cell.
// ============================================================================
module hpli_cell
    import hpli_pkg::*;
#(
    parameter int unsigned CELL_INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] probe_key,
    input  hpli_tok_t   tok_in,
    output hpli_tok_t   tok_out,
    input  hpli_wr_t    wr
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

    logic [63:0] key_reg,   key_next;
    logic [19:0] depth_reg, depth_next;
    logic [31:0] age_reg,   age_next;
    hpli_tok_t   tok_reg,   tok_next;
    logic        sel;

    assign sel = wr.en && (wr.idx == MY_IDX);

    always_comb
    begin
        tok_next = tok_in;
        // The probe key is never zero, so an empty slot cannot match it.
        if (!tok_in.match && (key_reg == probe_key))
        begin
            tok_next.match       = 1'b1;
            tok_next.match_idx   = MY_IDX;
            tok_next.match_depth = depth_reg;
        end
        if (!tok_in.empty && (key_reg == 64'd0))
        begin
            tok_next.empty     = 1'b1;
            tok_next.empty_idx = MY_IDX;
        end
        // Strict compare keeps the lowest index on equal ages.
        if (age_reg < tok_in.min_age)
        begin
            tok_next.min_age = age_reg;
            tok_next.min_idx = MY_IDX;
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        depth_next = depth_reg;
        age_next   = age_reg;
        if (wr.clear_all)
        begin
            key_next   = '0;
            depth_next = '0;
            age_next   = '0;
        end
        else if (sel)
        begin
            if (wr.key_en)
            begin
                key_next = wr.key;
            end
            if (wr.depth_en)
            begin
                depth_next = wr.depth;
            end
            if (wr.age_en)
            begin
                age_next = wr.age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            depth_reg <= '0;
            age_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            depth_reg <= depth_next;
            age_reg   <= age_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/hashed_prefix_lru_index.sv
// ============================================================================
// hashed_prefix_lru_index
// Prompt prefix table: FNV-1a hash of streamed bytes, LRU slot replacement.
// ============================================================================
// Usage:
//   Input beats are taken on start while busy is low, one beat per cycle.
//   A beat without last_byte only folds its byte into the running hash and
//   leaves busy low, so prompt bytes stream at one per clock.
//   A beat with last_byte finishes the hash and runs cmd on the table. A
//   search token then walks the row of SLOT_COUNT slot cells, one cell per
//   cycle, and the table is updated when it leaves the last cell. busy is
//   high from the accepting edge until the result beat appears on result
//   with done high for one cycle; the length of the cell row sets how long
//   a closing beat takes.
//   The result must be taken in the cycle done is high; the receiver cannot
//   stall it, and a new beat may be started in that same cycle.
//   Reset empties every slot, clears the counters and the use tick, and
//   loads the running hash with the FNV offset basis.
// ============================================================================
`include "hashed_prefix_lru_index_macros.svh"

module hashed_prefix_lru_index
    import hpli_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  hpli_in_t  item,
    output logic      done,
    output hpli_out_t result
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t       state_reg,  state_next;
    logic [63:0]  hash_reg,   hash_next;
    logic [63:0]  key_reg,    key_next;
    hpli_cmd_t    cmd_reg,    cmd_next;
    logic [19:0]  count_reg,  count_next;
    logic         launch_reg, launch_next;
    logic [31:0]  tick_reg,   tick_next;
    logic [63:0]  hit_reg,    hit_next;
    logic [63:0]  miss_reg,   miss_next;
    logic [63:0]  saved_reg,  saved_next;
    logic         done_reg,   done_next;
    hpli_out_t    result_reg, result_next;

    logic         accept;
    logic         apply;
    logic [63:0]  folded;
    logic [SLOT_IDX_W-1:0] victim;
    hpli_tok_t    tok_head;
    hpli_tok_t    tok [SLOT_COUNT+1];
    hpli_tok_t    tok_end;
    hpli_wr_t     wr;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign tok_end = tok[SLOT_COUNT];
    assign apply   = (state_reg == S_SCAN) && tok_end.valid;
    assign folded  = item.byte_valid ? fnv_fold(hash_reg, item.data_byte) : hash_reg;

    always_comb
    begin
        tok_head         = '0;
        tok_head.valid   = launch_reg;
        tok_head.min_age = '1;
    end

    assign tok[0] = tok_head;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        hpli_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .probe_key(key_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .wr       (wr)
        );
    end

    // A matching slot wins, then the first empty slot, else the oldest one.
    assign victim = tok_end.match ? tok_end.match_idx :
                    tok_end.empty ? tok_end.empty_idx : tok_end.min_idx;

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        key_next    = key_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        launch_next = 1'b0;
        tick_next   = tick_reg;
        hit_next    = hit_reg;
        miss_next   = miss_reg;
        saved_next  = saved_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr          = '0;
        wr.key      = key_reg;
        wr.depth    = count_reg;
        wr.age      = tick_reg + 32'd1;
        wr.idx      = victim;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.last_byte)
                    begin
                        key_next    = (folded == 64'd0) ? 64'd1 : folded;
                        hash_next   = FNV_BASIS;
                        cmd_next    = item.cmd;
                        count_next  = item.count_value;
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        hash_next = folded;
                    end
                end
            end
            S_SCAN:
            begin
                if (apply)
                begin
                    result_next.status      = STATUS_OK;
                    result_next.found_depth = '0;
                    unique case (cmd_reg)
                        CMD_RECORD:
                        begin
                            if (count_reg == 20'd0)
                            begin
                                result_next.status = STATUS_INVALID;
                            end
                            else
                            begin
                                tick_next   = tick_reg + 32'd1;
                                wr.en       = 1'b1;
                                wr.key_en   = 1'b1;
                                wr.depth_en = 1'b1;
                                wr.age_en   = 1'b1;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (tok_end.match)
                            begin
                                result_next.found_depth = tok_end.match_depth;
                                tick_next = tick_reg + 32'd1;
                                hit_next  = hit_reg + 64'd1;
                                wr.en     = 1'b1;
                                wr.age_en = 1'b1;
                            end
                            else
                            begin
                                miss_next          = miss_reg + 64'd1;
                                result_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wr.clear_all = 1'b1;
                        end
                        CMD_SAVINGS:
                        begin
                            saved_next = saved_reg + 64'(count_reg);
                        end
                    endcase
                    result_next.hit_total   = hit_next;
                    result_next.miss_total  = miss_next;
                    result_next.saved_total = saved_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hash_reg   <= FNV_BASIS;
            key_reg    <= '0;
            cmd_reg    <= CMD_RECORD;
            count_reg  <= '0;
            launch_reg <= 1'b0;
            tick_reg   <= '0;
            hit_reg    <= '0;
            miss_reg   <= '0;
            saved_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            key_reg    <= key_next;
            cmd_reg    <= cmd_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
            tick_reg   <= tick_next;
            hit_reg    <= hit_next;
            miss_reg   <= miss_next;
            saved_reg  <= saved_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `HPLI_ASSERT_IMP(a_token_end_in_scan, tok_end.valid, state_reg == S_SCAN)
    `HPLI_ASSERT_NEXT(a_done_single_beat, done_reg, !done_reg)
    `HPLI_ASSERT_NEXT(a_last_goes_busy, accept && item.last_byte, busy && !done_reg)
    `HPLI_ASSERT_NEXT(a_byte_no_result, accept && !item.last_byte, !busy && !done_reg)

endmodule

### dv/hashed_prefix_lru_index_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// hashed_prefix_lru_index_checker
// Watches the command and result channels of the prefix index, keeps its own
// copy of the hash, the slot table and the counters, and compares every
// result beat field by field with the oldest predicted result.
// ============================================================================
module hashed_prefix_lru_index_checker
    import hpli_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  hpli_in_t  item,
    input  logic      done,
    input  hpli_out_t result,
    output int        error_count,
    output int        pending
);

    localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME   = 64'h00000100000001b3;

    logic [63:0] prompt_hash;
    logic [63:0] slot_key   [SLOT_COUNT];
    logic [19:0] slot_depth [SLOT_COUNT];
    logic [31:0] slot_age   [SLOT_COUNT];
    logic [31:0] use_tick;
    logic [63:0] hits;
    logic [63:0] misses;
    logic [63:0] saved;
    hpli_out_t   expected_results [$];

    // Folds one beat into the hash; a closing beat runs its command on the
    // table copy and queues the result the block should report.
    task automatic predict_beat(input hpli_in_t beat);
        logic [63:0] key;
        hpli_out_t   res;
        int          hit_idx;
        int          victim;
        if (beat.byte_valid)
        begin
            prompt_hash = (prompt_hash ^ {56'd0, beat.data_byte}) * HASH_PRIME;
        end
        if (!beat.last_byte)
        begin
            return;
        end
        key = (prompt_hash == 64'd0) ? 64'd1 : prompt_hash;
        prompt_hash = OFFSET_BASIS;
        res.status = STATUS_OK;
        res.found_depth = '0;
        hit_idx = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_idx < 0 && slot_key[i] == key)
            begin
                hit_idx = i;
            end
        end
        case (beat.cmd)
            CMD_RECORD:
            begin
                if (beat.count_value == 20'd0)
                begin
                    res.status = STATUS_INVALID;
                end
                else
                begin
                    use_tick = use_tick + 32'd1;
                    if (hit_idx < 0)
                    begin
                        // First empty slot wins; otherwise the oldest age,
                        // the lowest index on a tie.
                        victim = -1;
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (victim < 0 && slot_key[i] == 64'd0)
                            begin
                                victim = i;
                            end
                        end
                        if (victim < 0)
                        begin
                            victim = 0;
                            for (int i = 1; i < SLOT_COUNT; i++)
                            begin
                                if (slot_age[i] < slot_age[victim])
                                begin
                                    victim = i;
                                end
                            end
                        end
                        hit_idx = victim;
                        slot_key[hit_idx] = key;
                    end
                    slot_depth[hit_idx] = beat.count_value;
                    slot_age[hit_idx] = use_tick;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit_idx < 0)
                begin
                    misses = misses + 64'd1;
                    res.status = STATUS_NOT_FOUND;
                end
                else
                begin
                    res.found_depth = slot_depth[hit_idx];
                    use_tick = use_tick + 32'd1;
                    slot_age[hit_idx] = use_tick;
                    hits = hits + 64'd1;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slot_key[i] = '0;
                    slot_depth[i] = '0;
                    slot_age[i] = '0;
                end
            end
            default:
            begin
                saved = saved + {44'd0, beat.count_value};
            end
        endcase
        res.hit_total = hits;
        res.miss_total = misses;
        res.saved_total = saved;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count = error_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hpli_out_t want;
        if (!rst_n)
        begin
            prompt_hash = OFFSET_BASIS;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_key[i] = '0;
                slot_depth[i] = '0;
                slot_age[i] = '0;
            end
            use_tick = '0;
            hits = '0;
            misses = '0;
            saved = '0;
            expected_results.delete();
            error_count = 0;
        end
        else
        begin
            // A new beat may start in the cycle a result leaves, so the
            // result is matched before the new beat is predicted.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no command waiting: status %0d",
                           result.status);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(result.status));
                    check_field("found_depth", 64'(want.found_depth),
                                64'(result.found_depth));
                    check_field("hit_total", want.hit_total, result.hit_total);
                    check_field("miss_total", want.miss_total, result.miss_total);
                    check_field("saved_total", want.saved_total, result.saved_total);
                end
            end
            if (start && !busy)
            begin
                predict_beat(item);
            end
        end
        pending = expected_results.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the hashed prefix LRU index. A directed pass walks
// the table through misses, hits, updates, eviction, clear and savings; then
// random prompts, mostly from a small reused pool, drive records, lookups,
// clears and savings that hit, miss and evict, with random gaps between beats.
// ============================================================================
module tb;
    import hpli_pkg::*;

    localparam int unsigned SLOTS       = 4;
    localparam int          BEAT_TARGET = 750;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          POOL_SIZE   = 8;
    localparam int          MAX_LEN     = 6;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    hpli_in_t  item;
    hpli_out_t result;
    int        error_count;
    int        pending;
    int        cycle_count;
    int        beats_sent;
    bit        steady;

    // Entry POOL_SIZE is scratch space for one-off prompts.
    logic [7:0] prompt_bytes [0:POOL_SIZE][0:MAX_LEN-1];
    int         prompt_len   [0:POOL_SIZE];

    hashed_prefix_lru_index #(.SLOT_COUNT(SLOTS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    hashed_prefix_lru_index_checker #(.SLOT_COUNT(SLOTS)) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Holds start high until the block takes the beat; start stays high
    // into the next beat when no gap is drawn.
    task automatic send_beat(input hpli_in_t beat);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= beat;
        do @(posedge clk); while (busy);
    endtask

    task automatic randomize_prompt(input int p);
        prompt_len[p] = int'($urandom_range(0, MAX_LEN));
        for (int i = 0; i < MAX_LEN; i++)
        begin
            prompt_bytes[p][i] = 8'($urandom);
        end
    endtask

    // Streams one prompt; the closing beat carries the command. Empty
    // prompts, and some others, close with a beat that holds no byte.
    task automatic run_prompt(input hpli_cmd_t op, input int p, input logic [19:0] amount);
        hpli_in_t beat;
        hpli_in_t noise;
        bit       close_empty;
        close_empty = (prompt_len[p] == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < prompt_len[p]; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                noise.cmd = hpli_cmd_t'(2'($urandom));
                noise.data_byte = 8'($urandom);
                noise.byte_valid = 1'b0;
                noise.last_byte = 1'b0;
                noise.count_value = 20'($urandom);
                send_beat(noise);
            end
            beat.cmd = hpli_cmd_t'(2'($urandom));
            beat.data_byte = prompt_bytes[p][i];
            beat.byte_valid = 1'b1;
            beat.last_byte = !close_empty && (i == prompt_len[p] - 1);
            beat.count_value = 20'($urandom);
            if (beat.last_byte)
            begin
                beat.cmd = op;
                beat.count_value = amount;
            end
            send_beat(beat);
            beats_sent++;
        end
        if (close_empty)
        begin
            beat.cmd = op;
            beat.data_byte = 8'($urandom);
            beat.byte_valid = 1'b0;
            beat.last_byte = 1'b1;
            beat.count_value = amount;
            send_beat(beat);
            beats_sent++;
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          p;
        logic [19:0] amount;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        steady = 1'b0;
        beats_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        prompt_len[0] = 0;
        prompt_len[1] = 2;
        prompt_bytes[1][0] = 8'h00;
        prompt_bytes[1][1] = 8'hff;
        prompt_len[2] = 1;
        prompt_bytes[2][0] = 8'h55;
        prompt_len[3] = 1;
        prompt_bytes[3][0] = 8'haa;
        prompt_len[4] = 1;
        prompt_bytes[4][0] = 8'h0f;

        run_prompt(CMD_LOOKUP, 0, 20'd0);
        run_prompt(CMD_RECORD, 0, 20'hfffff);
        run_prompt(CMD_LOOKUP, 0, 20'd0);
        run_prompt(CMD_RECORD, 1, 20'd0);
        run_prompt(CMD_RECORD, 1, 20'd1);
        run_prompt(CMD_RECORD, 2, 20'd2);
        run_prompt(CMD_RECORD, 3, 20'd3);
        run_prompt(CMD_LOOKUP, 1, 20'd0);
        run_prompt(CMD_RECORD, 1, 20'h80000);
        // Table is full; the empty prompt holds the oldest age and goes.
        run_prompt(CMD_RECORD, 4, 20'd4);
        run_prompt(CMD_LOOKUP, 0, 20'd0);
        run_prompt(CMD_LOOKUP, 4, 20'd0);
        run_prompt(CMD_SAVINGS, 2, 20'hfffff);
        run_prompt(CMD_SAVINGS, 3, 20'd0);
        run_prompt(CMD_CLEAR, 4, 20'h12345);
        run_prompt(CMD_LOOKUP, 2, 20'd0);
        drain();

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            randomize_prompt(i);
        end
        while (beats_sent < BEAT_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 49) == 0)
            begin
                randomize_prompt(int'($urandom_range(0, POOL_SIZE - 1)));
            end
            p = int'($urandom_range(0, POOL_SIZE - 1));
            if ($urandom_range(0, 9) == 0)
            begin
                p = POOL_SIZE;
                randomize_prompt(p);
            end
            pick = int'($urandom_range(0, 99));
            amount = 20'($urandom);
            if (pick < 35)
            begin
                case ($urandom_range(0, 19))
                    0: amount = 20'd0;
                    1: amount = 20'hfffff;
                    default: amount = 20'($urandom) >> $urandom_range(0, 19);
                endcase
                run_prompt(CMD_RECORD, p, amount);
            end
            else if (pick < 80)
            begin
                run_prompt(CMD_LOOKUP, p, amount);
            end
            else if (pick < 85)
            begin
                run_prompt(CMD_CLEAR, p, amount);
            end
            else
            begin
                run_prompt(CMD_SAVINGS, p, amount);
            end
            if ($urandom_range(0, 99) == 0)
            begin
                drain();
            end
        end

        steady = 1'b0;
        drain();
        repeat (SLOTS + 8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
